### rtl/grid_cell_reservation_table_top_defines.svh
// ---------------------------------------------------------------------------
// Grid cell reservation table: assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef GRID_CELL_RESERVATION_TABLE_TOP_DEFINES_SVH
`define GRID_CELL_RESERVATION_TABLE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define GCRT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("grid cell reservation table: property failed");

// next-cycle implication, sampled on clock, off while reset is high
`define GCRT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("grid cell reservation table: property failed");

`endif

### rtl/gcrt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid cell reservation table: package
// Cell status, request and response codes, controller/datapath link types.
// ---------------------------------------------------------------------------
package gcrt_pkg;

   localparam logic [1:0] ST_FREE = 2'd0;
   localparam logic [1:0] ST_OCC  = 2'd1;
   localparam logic [1:0] ST_PRE  = 2'd2;

   localparam logic [1:0] RSP_WAIT   = 2'd0;
   localparam logic [1:0] RSP_GO     = 2'd1;
   localparam logic [1:0] RSP_CHANGE = 2'd2;
   localparam logic [1:0] RSP_NONE   = 2'd3;

   localparam logic [1:0] TYPE_RELEASE = 2'd0;
   localparam logic [1:0] TYPE_OCCUPY  = 2'd1;

   localparam logic [1:0] COUNT_ONE = 2'd1;
   localparam logic [1:0] COUNT_TWO = 2'd2;

   typedef struct packed {
      logic clear;
      logic accept;
      logic eval;
      logic write_b;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need_b;
   } sts_type;

endpackage

### rtl/grid_cell_reservation_table_top.sv
`timescale 1ns / 1ps
// The result is registered: a taken request is evaluated and, when a second cell is preoccupied,
// that cell is written in a state of its own, as the cell table has a single write port.
// Requests are taken one at a time: req_stall stays high until the result is loaded.
// Reset: synchronous; afterwards the table is swept clear, all GRID_SIDE*GRID_SIDE cells
// (1024 at the default size), with req_stall high throughout.
// ---------------------------------------------------------------------------
// Grid cell reservation table: top level
// Occupy, release and two-cell reservation requests against a square cell grid.
// ---------------------------------------------------------------------------
module grid_cell_reservation_table_top #(
   parameter int GRID_SIDE  = 32,
   parameter int OWNER_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [1:0] req_point_count,
   input  logic [7:0] req_requester_id,
   input  logic [4:0] req_row_a,
   input  logic [4:0] req_col_a,
   input  logic [4:0] req_row_b,
   input  logic [4:0] req_col_b,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_response
);

   gcrt_pkg::cmd_type cmd;
   gcrt_pkg::sts_type sts;

   gcrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   gcrt_dp #(
      .GRID_SIDE  (GRID_SIDE),
      .OWNER_BITS (OWNER_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_point_count  (req_point_count),
      .req_requester_id (req_requester_id),
      .req_row_a        (req_row_a),
      .req_col_a        (req_col_a),
      .req_row_b        (req_row_b),
      .req_col_b        (req_col_b),
      .rsp_response     (rsp_response)
   );

endmodule

### rtl/gcrt_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid cell reservation table: controller
// Sequences the clearing sweep, request capture, table update and result.
// ---------------------------------------------------------------------------
module gcrt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gcrt_pkg::cmd_type cmd,
   input  gcrt_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_WRB,
      S_PUSH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_stall_ff, req_stall_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.need_b) begin
               state_in = S_WRB;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_WRB: begin
            cmd.write_b = 1'b1;
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   assign req_stall_in = (state_in != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         req_stall_ff <= req_stall_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign req_stall = req_stall_ff;

endmodule

### rtl/gcrt_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid cell reservation table: datapath
// Cell table memory, request registers, decision logic and result register.
// ---------------------------------------------------------------------------
module gcrt_dp #(
   parameter int GRID_SIDE  = 32,
   parameter int OWNER_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  gcrt_pkg::cmd_type cmd,
   output gcrt_pkg::sts_type sts,
   input  logic [1:0]        req_type,
   input  logic [1:0]        req_point_count,
   input  logic [7:0]        req_requester_id,
   input  logic [4:0]        req_row_a,
   input  logic [4:0]        req_col_a,
   input  logic [4:0]        req_row_b,
   input  logic [4:0]        req_col_b,
   output logic [1:0]        rsp_response
);

   localparam int          CELLS  = GRID_SIDE * GRID_SIDE;
   localparam int          ADDR_W = $clog2(CELLS);
   localparam int          ENT_W  = 2 + OWNER_BITS;
   localparam logic [31:0] SIDE_U = 32'(GRID_SIDE);

   logic [ENT_W-1:0] cell_mem [CELLS];

   logic                  ok_a, ok_b;
   logic [31:0]           idx_a, idx_b;
   logic [ADDR_W-1:0]     addr_a, addr_b;
   logic [OWNER_BITS-1:0] who;

   logic [1:0]            type_ff, count_ff;
   logic [OWNER_BITS-1:0] who_ff;
   logic [ADDR_W-1:0]     addr_a_ff, addr_b_ff;
   logic                  ok_a_ff, ok_b_ff;
   logic [ENT_W-1:0]      rd_a_ff, rd_b_ff;
   logic [ADDR_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [1:0]            resp_ff;
   logic [1:0]            rsp_response_ff;

   logic [1:0]            st_a, st_b, sa, sb;
   logic [OWNER_BITS-1:0] own_a, own_b;
   logic [1:0]            resp;
   logic                  write_a, need_b;
   logic [1:0]            a_status;
   logic [OWNER_BITS-1:0] a_owner;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ENT_W-1:0]      wr_data;

   // map request cells to table addresses
   assign ok_a   = (32'(req_row_a) < SIDE_U) && (32'(req_col_a) < SIDE_U);
   assign ok_b   = (32'(req_row_b) < SIDE_U) && (32'(req_col_b) < SIDE_U);
   assign idx_a  = 32'(req_row_a) * SIDE_U + 32'(req_col_a);
   assign idx_b  = 32'(req_row_b) * SIDE_U + 32'(req_col_b);
   assign addr_a = ok_a ? idx_a[ADDR_W-1:0] : '0;
   assign addr_b = ok_b ? idx_b[ADDR_W-1:0] : '0;
   assign who    = OWNER_BITS'(64'(req_requester_id));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff   <= req_type;
         count_ff  <= req_point_count;
         who_ff    <= who;
         addr_a_ff <= addr_a;
         addr_b_ff <= addr_b;
         ok_a_ff   <= ok_a;
         ok_b_ff   <= ok_b;
      end
   end

   // masked statuses: a cell held by the requester reads as free
   assign st_a  = rd_a_ff[ENT_W-1 -: 2];
   assign st_b  = rd_b_ff[ENT_W-1 -: 2];
   assign own_a = rd_a_ff[OWNER_BITS-1:0];
   assign own_b = rd_b_ff[OWNER_BITS-1:0];
   assign sa    = ((st_a == gcrt_pkg::ST_OCC || st_a == gcrt_pkg::ST_PRE) && own_a == who_ff)
                  ? gcrt_pkg::ST_FREE : st_a;
   assign sb    = ((st_b == gcrt_pkg::ST_OCC || st_b == gcrt_pkg::ST_PRE) && own_b == who_ff)
                  ? gcrt_pkg::ST_FREE : st_b;

   always_comb begin
      resp     = gcrt_pkg::RSP_NONE;
      write_a  = 1'b0;
      need_b   = 1'b0;
      a_status = gcrt_pkg::ST_OCC;
      a_owner  = who_ff;
      if (count_ff == gcrt_pkg::COUNT_ONE && ok_a_ff) begin
         if (type_ff == gcrt_pkg::TYPE_OCCUPY) begin
            if (sa == gcrt_pkg::ST_FREE || sa == gcrt_pkg::ST_PRE) begin
               write_a = 1'b1;
               resp    = gcrt_pkg::RSP_GO;
            end else begin
               resp = gcrt_pkg::RSP_WAIT;
            end
         end else if (type_ff == gcrt_pkg::TYPE_RELEASE) begin
            if (own_a == who_ff) begin
               write_a  = 1'b1;
               a_status = gcrt_pkg::ST_FREE;
               a_owner  = '0;
            end
            resp = gcrt_pkg::RSP_GO;
         end
      end else if (count_ff == gcrt_pkg::COUNT_TWO && ok_a_ff && ok_b_ff) begin
         if (sa == gcrt_pkg::ST_OCC) begin
            resp = gcrt_pkg::RSP_WAIT;
         end else if (sa == gcrt_pkg::ST_PRE && sb == gcrt_pkg::ST_OCC) begin
            resp = (own_a == own_b) ? gcrt_pkg::RSP_CHANGE : gcrt_pkg::RSP_WAIT;
         end else if (sb == gcrt_pkg::ST_FREE) begin
            write_a = 1'b1;
            need_b  = 1'b1;
            resp    = gcrt_pkg::RSP_GO;
         end else begin
            write_a = 1'b1;
            resp    = gcrt_pkg::RSP_GO;
         end
      end
   end

   assign sts.need_b     = need_b;
   assign sts.clear_last = (clr_cnt_ff == ADDR_W'(CELLS - 1));

   // one write port: clearing sweep, first cell, second cell
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_cnt_ff;
      wr_data = '0;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.eval) begin
         wr_en   = write_a;
         wr_addr = addr_a_ff;
         wr_data = {a_status, a_owner};
      end else if (cmd.write_b) begin
         wr_en   = 1'b1;
         wr_addr = addr_b_ff;
         wr_data = {gcrt_pkg::ST_PRE, who_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
      if (cmd.accept) begin
         rd_a_ff <= cell_mem[addr_a];
         rd_b_ff <= cell_mem[addr_b];
      end
   end

   assign clr_cnt_in = cmd.clear ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         resp_ff <= resp;
      end
      if (cmd.load_out) begin
         rsp_response_ff <= cmd.eval ? resp : resp_ff;
      end
   end

   assign rsp_response = rsp_response_ff;

endmodule

### rtl/gcrt_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid cell reservation table: port checker
// Request/result ordering and reset behaviour seen at the top-level ports.
// ---------------------------------------------------------------------------
`include "grid_cell_reservation_table_top_defines.svh"

module gcrt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_response
);

   `GCRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_response))
   `GCRT_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)
   `GCRT_ASSERT_IMPL(a_rsp_from_req, $rose(rsp_valid), $past(req_stall))
   `GCRT_ASSERT_IMPL(a_reset_state, $past(reset), req_stall && !rsp_valid)

endmodule

bind grid_cell_reservation_table_top gcrt_checker u_checker (.*);

### tb/grid_cell_reservation_table_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid cell reservation table: testbench
// Drives one- and two-cell requests, plus some with unused type and count codes, from a queue
// through a clocked driver, predicts each response from a private copy of the cell table and
// checks it in a clocked monitor, with random request gaps and random response stalls.
// ---------------------------------------------------------------------------
module grid_cell_reservation_table_top_tb;

   localparam int GRID_SIDE      = 32;
   localparam int CELL_COUNT     = GRID_SIDE * GRID_SIDE;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PHASE_ITEMS    = 465;

   localparam logic [1:0] TYPE_PREOCCUPY = 2'd2;
   localparam logic [1:0] TYPE_SPARE     = 2'd3;
   localparam logic [1:0] COUNT_NONE     = 2'd0;
   localparam logic [1:0] COUNT_SPARE    = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] count;
      logic [7:0] who;
      logic [4:0] row_a;
      logic [4:0] col_a;
      logic [4:0] row_b;
      logic [4:0] col_b;
   } cell_request_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = '0;
   logic [1:0] req_point_count = '0;
   logic [7:0] req_requester_id = '0;
   logic [4:0] req_row_a = '0;
   logic [4:0] req_col_a = '0;
   logic [4:0] req_row_b = '0;
   logic [4:0] req_col_b = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_response;

   cell_request_type pending_requests[$];
   logic [1:0]       expected_responses[$];

   logic [1:0] cell_status[CELL_COUNT];
   logic [7:0] cell_owner[CELL_COUNT];

   int unsigned n_queued = 0;
   int unsigned n_accepted = 0;
   int unsigned n_checked = 0;
   int unsigned n_errors = 0;
   int unsigned idle_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;

   logic [4:0] win_row;
   logic [4:0] win_col;
   int unsigned win_span;
   logic [7:0] robot_pool[4];

   grid_cell_reservation_table_top #(
      .GRID_SIDE  (GRID_SIDE),
      .OWNER_BITS (8)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_point_count  (req_point_count),
      .req_requester_id (req_requester_id),
      .req_row_a        (req_row_a),
      .req_col_a        (req_col_a),
      .req_row_b        (req_row_b),
      .req_col_b        (req_col_b),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_response     (rsp_response)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [1:0] masked_status(int unsigned idx, logic [7:0] who);
      if ((cell_status[idx] == gcrt_pkg::ST_OCC || cell_status[idx] == gcrt_pkg::ST_PRE) &&
          cell_owner[idx] == who) return gcrt_pkg::ST_FREE;
      return cell_status[idx];
   endfunction

   function automatic void claim_cell(int unsigned idx, logic [1:0] st, logic [7:0] who);
      cell_status[idx] = st;
      cell_owner[idx]  = who;
   endfunction

   function automatic logic [1:0] predict_response(cell_request_type rq);
      int unsigned ia;
      int unsigned ib;
      logic [1:0]  sa;
      logic [1:0]  sb;
      logic [1:0]  rsp;
      rsp = gcrt_pkg::RSP_NONE;
      ia  = int'(rq.row_a) * GRID_SIDE + int'(rq.col_a);
      ib  = int'(rq.row_b) * GRID_SIDE + int'(rq.col_b);
      if (rq.row_a < GRID_SIDE && rq.col_a < GRID_SIDE) begin
         if (rq.count == gcrt_pkg::COUNT_ONE) begin
            if (rq.kind == gcrt_pkg::TYPE_OCCUPY) begin
               sa = masked_status(ia, rq.who);
               if (sa == gcrt_pkg::ST_FREE || sa == gcrt_pkg::ST_PRE) begin
                  claim_cell(ia, gcrt_pkg::ST_OCC, rq.who);
                  rsp = gcrt_pkg::RSP_GO;
               end else begin
                  rsp = gcrt_pkg::RSP_WAIT;
               end
            end else if (rq.kind == gcrt_pkg::TYPE_RELEASE) begin
               if (cell_owner[ia] == rq.who) claim_cell(ia, gcrt_pkg::ST_FREE, 8'd0);
               rsp = gcrt_pkg::RSP_GO;
            end
         end else if (rq.count == gcrt_pkg::COUNT_TWO &&
                      rq.row_b < GRID_SIDE && rq.col_b < GRID_SIDE) begin
            sa = masked_status(ia, rq.who);
            sb = masked_status(ib, rq.who);
            if (sa == gcrt_pkg::ST_OCC) begin
               rsp = gcrt_pkg::RSP_WAIT;
            end else if (sa == gcrt_pkg::ST_PRE && sb == gcrt_pkg::ST_OCC) begin
               rsp = (cell_owner[ia] == cell_owner[ib]) ? gcrt_pkg::RSP_CHANGE
                                                        : gcrt_pkg::RSP_WAIT;
            end else if (sb == gcrt_pkg::ST_FREE) begin
               claim_cell(ia, gcrt_pkg::ST_OCC, rq.who);
               claim_cell(ib, gcrt_pkg::ST_PRE, rq.who);
               rsp = gcrt_pkg::RSP_GO;
            end else begin
               claim_cell(ia, gcrt_pkg::ST_OCC, rq.who);
               rsp = gcrt_pkg::RSP_GO;
            end
         end
      end
      return rsp;
   endfunction

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [4:0] window_step(logic [4:0] base, logic [4:0] pos);
      int p;
      p = int'(pos) + $urandom_range(0, 2) - 1;
      if (p < int'(base)) p = int'(base);
      if (p > int'(base) + int'(win_span) - 1) p = int'(base) + int'(win_span) - 1;
      return p[4:0];
   endfunction

   function automatic cell_request_type random_request();
      cell_request_type rq;
      int unsigned      r;
      r        = $urandom_range(0, 99);
      rq.who   = robot_pool[$urandom_range(0, 3)];
      rq.row_a = win_row + 5'($urandom_range(0, win_span - 1));
      rq.col_a = win_col + 5'($urandom_range(0, win_span - 1));
      rq.row_b = window_step(win_row, rq.row_a);
      rq.col_b = window_step(win_col, rq.col_a);
      rq.kind  = ($urandom_range(0, 99) < 55) ? gcrt_pkg::TYPE_OCCUPY : gcrt_pkg::TYPE_RELEASE;
      rq.count = ($urandom_range(0, 99) < 55) ? gcrt_pkg::COUNT_TWO : gcrt_pkg::COUNT_ONE;
      if (r < 10) begin
         rq = cell_request_type'({$urandom, $urandom});
         rq.count = ($urandom_range(0, 1) == 1) ? gcrt_pkg::COUNT_TWO : gcrt_pkg::COUNT_ONE;
         rq.kind  = 2'($urandom_range(0, 1));
      end else if (r < 15) begin
         if ($urandom_range(0, 1) == 1) begin
            rq.count = ($urandom_range(0, 1) == 1) ? COUNT_SPARE : COUNT_NONE;
            rq.kind  = 2'($urandom_range(0, 3));
         end else begin
            rq.count = gcrt_pkg::COUNT_ONE;
            rq.kind  = ($urandom_range(0, 1) == 1) ? TYPE_SPARE : TYPE_PREOCCUPY;
         end
      end
      return rq;
   endfunction

   task automatic push_request(logic [1:0] kind, logic [1:0] count, logic [7:0] who,
                               logic [4:0] ra, logic [4:0] ca, logic [4:0] rb, logic [4:0] cb);
      cell_request_type rq;
      rq = '{kind, count, who, ra, ca, rb, cb};
      pending_requests.push_back(rq);
      n_queued++;
   endtask

   // driver
   always @(posedge clock) begin
      cell_request_type rq;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            rq = '{req_type, req_point_count, req_requester_id,
                   req_row_a, req_col_a, req_row_b, req_col_b};
            expected_responses.push_back(predict_response(rq));
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               rq = pending_requests.pop_front();
               req_type         <= rq.kind;
               req_point_count  <= rq.count;
               req_requester_id <= rq.who;
               req_row_a        <= rq.row_a;
               req_col_a        <= rq.col_a;
               req_row_b        <= rq.row_b;
               req_col_b        <= rq.col_b;
               req_valid        <= 1'b1;
               send_gap         <= (n_accepted[8:7] == 2'b01) ? 0 : idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [1:0]  want;
      int unsigned len;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_checked++;
            if (expected_responses.size() == 0) begin
               if (n_errors < 10)
                  $display("%0t: response %0d with no request outstanding", $realtime,
                           rsp_response);
               n_errors++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_response !== want) begin
                  if (n_errors < 10)
                     $display("%0t: response #%0d expected %0d, got %0d", $realtime,
                              n_checked, want, rsp_response);
                  n_errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else begin
            len = (n_checked[8:7] == 2'b10) ? 0 : idle_length();
            if (len > 0) begin
               stall_left <= len - 1;
               rsp_stall  <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int phase;
      foreach (cell_status[i]) begin
         cell_status[i] = gcrt_pkg::ST_FREE;
         cell_owner[i]  = 8'd0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_ONE, 8'd1,
                   5'd0, 5'd0, 5'd0, 5'd0);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_ONE, 8'd2,
                   5'd0, 5'd0, 5'd0, 5'd0);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_ONE, 8'd1,
                   5'd0, 5'd0, 5'd0, 5'd0);
      push_request(gcrt_pkg::TYPE_RELEASE, gcrt_pkg::COUNT_ONE, 8'd2,
                   5'd0, 5'd0, 5'd0, 5'd0);
      push_request(gcrt_pkg::TYPE_RELEASE, gcrt_pkg::COUNT_ONE, 8'd1,
                   5'd0, 5'd0, 5'd0, 5'd0);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_ONE, 8'd255,
                   5'd31, 5'd31, 5'd31, 5'd31);
      push_request(TYPE_PREOCCUPY,         gcrt_pkg::COUNT_ONE, 8'd3,
                   5'd2, 5'd2, 5'd0, 5'd0);
      push_request(TYPE_SPARE,             gcrt_pkg::COUNT_ONE, 8'd3,
                   5'd2, 5'd2, 5'd0, 5'd0);
      push_request(gcrt_pkg::TYPE_OCCUPY,  COUNT_NONE,          8'd3,
                   5'd2, 5'd2, 5'd2, 5'd3);
      push_request(gcrt_pkg::TYPE_OCCUPY,  COUNT_SPARE,         8'd3,
                   5'd2, 5'd2, 5'd2, 5'd3);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_TWO, 8'd3,
                   5'd5, 5'd5, 5'd5, 5'd6);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_TWO, 8'd4,
                   5'd5, 5'd6, 5'd5, 5'd7);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_TWO, 8'd3,
                   5'd5, 5'd7, 5'd5, 5'd6);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_TWO, 8'd9,
                   5'd5, 5'd7, 5'd5, 5'd5);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_TWO, 8'd9,
                   5'd5, 5'd6, 5'd5, 5'd5);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_TWO, 8'd9,
                   5'd10, 5'd10, 5'd5, 5'd6);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_TWO, 8'd9,
                   5'd10, 5'd11, 5'd5, 5'd7);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_TWO, 8'd7,
                   5'd20, 5'd20, 5'd20, 5'd21);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_TWO, 8'd1,
                   5'd5, 5'd7, 5'd20, 5'd21);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_TWO, 8'd5,
                   5'd12, 5'd12, 5'd12, 5'd12);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_ONE, 8'd6,
                   5'd12, 5'd12, 5'd0, 5'd0);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_ONE, 8'd0,
                   5'd31, 5'd0, 5'd0, 5'd31);
      push_request(gcrt_pkg::TYPE_RELEASE, gcrt_pkg::COUNT_ONE, 8'd0,
                   5'd31, 5'd0, 5'd0, 5'd0);
      push_request(gcrt_pkg::TYPE_RELEASE, gcrt_pkg::COUNT_ONE, 8'd0,
                   5'd31, 5'd0, 5'd0, 5'd0);
      push_request(gcrt_pkg::TYPE_OCCUPY,  gcrt_pkg::COUNT_ONE, 8'd7,
                   5'd20, 5'd21, 5'd0, 5'd0);

      for (phase = 0; phase < 4; phase++) begin
         win_span = $urandom_range(3, 6);
         win_row  = 5'($urandom_range(0, GRID_SIDE - win_span));
         win_col  = 5'($urandom_range(0, GRID_SIDE - win_span));
         foreach (robot_pool[i]) robot_pool[i] = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1) == 1) robot_pool[0] = 8'd0;
         // queue no more requests until every queued one is taken and every outstanding response is back
         if (phase == 2)
            while (!(n_accepted == n_queued && expected_responses.size() == 0))
               @(posedge clock);
         repeat (PHASE_ITEMS) begin
            pending_requests.push_back(random_request());
            n_queued++;
         end
      end

      while (!(n_accepted == n_queued && expected_responses.size() == 0)) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
